>>> src/dss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

    localparam int DEFAULT_CAPACITY = 32;
    localparam int DATA_W           = 32;
    localparam int CNT_W            = 7;
    localparam int IDX_W            = 6;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_LIST   = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_PRESENT = 2'd1;
    localparam logic [1:0] STAT_ABSENT  = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    typedef logic signed [DATA_W-1:0] dss_word_t;

    // per-row command from the sequencer
    typedef struct packed {
        logic             add;
        logic             shift;
        logic             rotate;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] pos;
        dss_word_t        key;
    } dss_row_ctrl_t;

endpackage

`default_nettype wire

>>> src/dss_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dss_cell (
    input  logic             clk,
    input  logic             load,
    input  dss_pkg::dss_word_t load_data,
    input  dss_pkg::dss_word_t key,
    output dss_pkg::dss_word_t data,
    output logic             match
);
    import dss_pkg::*;

    dss_word_t data_reg;
    dss_word_t data_next;

    assign data_next = load ? load_data : data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == key);

endmodule

`default_nettype wire

>>> src/dss_row.sv
`timescale 1ns / 1ps
`default_nettype none

module dss_row #(
    parameter int CAPACITY = dss_pkg::DEFAULT_CAPACITY
) (
    input  logic                  clk,
    input  dss_pkg::dss_row_ctrl_t ctrl,
    output logic [CAPACITY-1:0]   match,
    output dss_pkg::dss_word_t    head
);
    import dss_pkg::*;

    dss_word_t cell_data [CAPACITY];

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            localparam int NXT = (i + 1) % CAPACITY;
            logic      in_use;
            logic      at_top;
            logic      load;
            dss_word_t load_data;
            logic      raw_match;

            assign in_use = (CNT_W'(i) < ctrl.count);
            assign at_top = (CNT_W'(i + 1) == ctrl.count);

            // add writes the free slot, remove closes the gap, list rotates the used part
            assign load = (ctrl.add && (CNT_W'(i) == ctrl.count))
                       || (ctrl.shift && (IDX_W'(i) >= ctrl.pos) && in_use && !at_top)
                       || (ctrl.rotate && in_use);

            assign load_data = ctrl.add ? ctrl.key
                             : ((ctrl.rotate && at_top) ? cell_data[0] : cell_data[NXT]);

            dss_cell u_cell (
                .clk       (clk),
                .load      (load),
                .load_data (load_data),
                .key       (ctrl.key),
                .data      (cell_data[i]),
                .match     (raw_match)
            );

            assign match[i] = raw_match && in_use;
        end
    endgenerate

    assign head = cell_data[0];

endmodule

`default_nettype wire

>>> src/dual_integer_set_store.sv
// add, remove and clear: accepted word, compare state, execute state; the result
// word is registered from the execute state once the output is free, and no new word
// is taken until the block is back in idle
// list: from the list state, one element per cycle from the head cell while the row
// rotates and the output is free; the next word is taken after the last element
// reset clears both member counts and the control state; the cell contents are not reset
`timescale 1ns / 1ps
`default_nettype none

module dual_integer_set_store #(
    parameter int CAPACITY = dss_pkg::DEFAULT_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic               set_select,
    input  dss_pkg::dss_word_t value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic               element_valid,
    output dss_pkg::dss_word_t element,
    output logic               last
);
    import dss_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_LIST = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       op_reg;
    logic             sel_reg;
    dss_word_t        key_reg;
    logic [CNT_W-1:0] count_reg [2];
    logic [CNT_W-1:0] count_next;
    logic             count_we;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] idx_reg, idx_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    logic             elem_valid_reg, elem_valid_next;
    dss_word_t        element_reg, element_next;
    logic             last_reg, last_next;

    logic [CAPACITY-1:0] match_a, match_b, match_sel;
    dss_word_t           head_a, head_b, head_sel;
    dss_row_ctrl_t       ctrl_a, ctrl_b;
    logic                out_free, emit;
    logic                act_add, act_shift, act_rotate;
    logic [CNT_W-1:0]    n_sel;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign n_sel     = count_reg[sel_reg];
    assign match_sel = sel_reg ? match_b : match_a;
    assign head_sel  = sel_reg ? head_b : head_a;

    // one-hot match to index; values are distinct so at most one bit is set
    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_sel[i])
            begin
                pos_next = pos_next | IDX_W'(i);
            end
        end
        found_next = |match_sel;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = n_sel;
        count_we        = 1'b0;
        emit            = 1'b0;
        status_next     = STAT_OK;
        elem_valid_next = 1'b0;
        element_next    = '0;
        last_next       = 1'b1;
        act_add         = 1'b0;
        act_shift       = 1'b0;
        act_rotate      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (found_reg)
                            begin
                                status_next = STAT_PRESENT;
                            end
                            else if (n_sel >= CNT_W'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                act_add    = 1'b1;
                                count_we   = 1'b1;
                                count_next = n_sel + 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!found_reg)
                            begin
                                status_next = STAT_ABSENT;
                            end
                            else
                            begin
                                act_shift  = 1'b1;
                                count_we   = 1'b1;
                                count_next = n_sel - 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_we   = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            // a non-empty list is streamed from the list state
                            if (n_sel != '0)
                            begin
                                emit       = 1'b0;
                                idx_next   = '0;
                                state_next = S_LIST;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    act_rotate      = 1'b1;
                    elem_valid_next = 1'b1;
                    element_next    = head_sel;
                    last_next       = (idx_reg + 1'b1 == n_sel);
                    idx_next        = idx_reg + 1'b1;
                    if (last_next)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        ctrl_a        = '0;
        ctrl_a.count  = count_reg[0];
        ctrl_a.pos    = pos_reg;
        ctrl_a.key    = key_reg;
        ctrl_a.add    = act_add && !sel_reg;
        ctrl_a.shift  = act_shift && !sel_reg;
        ctrl_a.rotate = act_rotate && !sel_reg;
        ctrl_b        = '0;
        ctrl_b.count  = count_reg[1];
        ctrl_b.pos    = pos_reg;
        ctrl_b.key    = key_reg;
        ctrl_b.add    = act_add && sel_reg;
        ctrl_b.shift  = act_shift && sel_reg;
        ctrl_b.rotate = act_rotate && sel_reg;
    end

    dss_row #(
        .CAPACITY (CAPACITY)
    ) u_row_a (
        .clk   (clk),
        .ctrl  (ctrl_a),
        .match (match_a),
        .head  (head_a)
    );

    dss_row #(
        .CAPACITY (CAPACITY)
    ) u_row_b (
        .clk   (clk),
        .ctrl  (ctrl_b),
        .match (match_b),
        .head  (head_b)
    );

    assign out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg[0]  <= '0;
            count_reg[1]  <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            if (count_we)
            begin
                count_reg[sel_reg] <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= operation;
            sel_reg <= set_select;
            key_reg <= value;
        end
        if (state_reg == S_CMP)
        begin
            found_reg <= found_next;
            pos_reg   <= pos_next;
        end
        if (emit)
        begin
            status_reg     <= status_next;
            elem_valid_reg <= elem_valid_next;
            element_reg    <= element_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign element_valid = elem_valid_reg;
    assign element       = element_reg;
    assign last          = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg[0] <= CNT_W'(CAPACITY)) && (count_reg[1] <= CNT_W'(CAPACITY)))
        else $error("member count above capacity");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> $onehot0(match_sel))
        else $error("value found in more than one cell");

    a_list_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> (idx_reg < n_sel))
        else $error("list index past member count");

    a_idle_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> ($stable(count_reg[0]) && $stable(count_reg[1])))
        else $error("member count changed while idle");

    a_list_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST && out_free) |=> (out_valid_reg && elem_valid_reg))
        else $error("list step did not present an element word");
`endif

endmodule

`default_nettype wire
